// ===== hdl/range_flip_range_count_macros.svh =====
`ifndef RANGE_FLIP_RANGE_COUNT_MACROS_SVH
`define RANGE_FLIP_RANGE_COUNT_MACROS_SVH

// same-cycle implication check, quiet while reset is asserted
`define RFRC_CHECK(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check, quiet while reset is asserted
`define RFRC_CHECK_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rfrc_pkg.sv =====
`default_nettype none

package rfrc_pkg;

    localparam int RANGE_W = 11;
    localparam int COUNT_W = 11;

    localparam logic FUNC_FLIP  = 1'b0;
    localparam logic FUNC_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_RD,
        ST_P_CHK,
        ST_P_WL,
        ST_P_WR,
        ST_A_STEP,
        ST_A_LEFT,
        ST_A_RIGHT,
        ST_B_RD,
        ST_B_SUM,
        ST_B_WR
    } state_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_FLIP_A,
        ALU_FLIP_B,
        ALU_SUM,
        ALU_FIX,
        ALU_TAKE_A,
        ALU_TAKE_B
    } alu_op_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/range_flip_range_count.sv =====
// Row of POSITIONS one-bit cards, all face up after reset, kept in a lazy segment
// tree of face-down counts and flip marks in one node memory (two registered read
// ports, one write port) worked on by a single add/subtract unit. After reset a
// clearing pass writes all 2*2^L node words with busy high, where L is
// ceil(log2(POSITIONS)), 2048 words at the default. An input word is taken when
// start is high and busy is low; busy then stays high until the walk ends. A count
// walks the two boundary paths pushing marks down, then collects the covering
// nodes; a flip also adds a bottom-up rebuild of both paths. A word whose range is
// empty after clipping starts no walk and leaves busy low. Each count result is
// shown on up_count for exactly one cycle with done high; there is no way to hold
// it off, so the receiver must take it in that cycle.
`default_nettype none

`include "range_flip_range_count_macros.svh"

module range_flip_range_count #(
    parameter int POSITIONS = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         func,
    input  wire logic [rfrc_pkg::RANGE_W-1:0] range_low,
    input  wire logic [rfrc_pkg::RANGE_W-1:0] range_high,
    output logic                              done,
    output logic [rfrc_pkg::COUNT_W-1:0]      up_count
);

    localparam int LEVELS = $clog2(POSITIONS);
    localparam int P2     = 1 << LEVELS;
    localparam int AW     = LEVELS + 1;
    localparam int CW     = LEVELS + 1;
    localparam int DW     = CW + 1;
    localparam int HW     = $clog2(LEVELS + 1);
    localparam int BW     = AW + 1;
    localparam int EW     = (LEVELS + 1 > rfrc_pkg::RANGE_W) ? LEVELS + 1 : rfrc_pkg::RANGE_W;
    localparam int OUT_W  = rfrc_pkg::COUNT_W;

    rfrc_pkg::state_t state_reg, state_next;

    logic              func_reg,  func_next;
    logic [AW-1:0]     pl_reg,    pl_next;
    logic [AW-1:0]     pr_reg,    pr_next;
    logic [LEVELS-1:0] lpath_reg, lpath_next;
    logic [LEVELS-1:0] rpath_reg, rpath_next;
    logic [BW-1:0]     l_reg,     l_next;
    logic [BW-1:0]     r_reg,     r_next;
    logic [HW-1:0]     h_reg,     h_next;
    logic              side_reg,  side_next;
    logic              lsel_reg,  lsel_next;
    logic              rsel_reg,  rsel_next;
    logic [CW-1:0]     acc_reg,   acc_next;
    logic [CW-1:0]     size_reg,  size_next;
    logic [CW-1:0]     sum_reg,   sum_next;
    logic [AW-1:0]     clr_reg,   clr_next;
    logic              done_reg,  done_next;
    logic [OUT_W-1:0]  up_reg,    up_next;

    // range clipping
    logic [EW-1:0]     lo_e, hi_e, lo_c, hi_c;
    logic              empty;
    logic [LEVELS-1:0] a0, b0;

    // walk helpers
    logic [AW-1:0]     p_cur;
    logic [AW-1:0]     c0_addr, c1_addr;
    logic [AW-1:0]     lnode, rnode;
    logic              same_node;
    logic              push_last;
    logic              push_done;
    logic              rebuild_done;
    logic [CW-1:0]     span_h, span_c;

    // node memory and shared unit
    rfrc_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
    logic [DW-1:0]      wr_data, rd_data_a, rd_data_b;
    rfrc_pkg::alu_op_t  alu_op;
    logic [CW-1:0]      alu_span, alu_res;

    rfrc_node_mem #(
        .AW (AW),
        .DW (DW)
    ) u_mem (
        .clk       (clk),
        .ctl       (mem_ctl),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rfrc_node_alu #(
        .CW (CW)
    ) u_alu (
        .op    (alu_op),
        .mark  (rd_data_a[CW]),
        .span  (alu_span),
        .acc   (acc_reg),
        .sum   (sum_reg),
        .cnt_a (rd_data_a[CW-1:0]),
        .cnt_b (rd_data_b[CW-1:0]),
        .res   (alu_res)
    );

    always_comb
    begin
        lo_e  = EW'(range_low);
        hi_e  = EW'(range_high);
        lo_c  = (lo_e == '0) ? EW'(1) : lo_e;
        hi_c  = (hi_e > EW'(POSITIONS)) ? EW'(POSITIONS) : hi_e;
        empty = (lo_c > hi_c);
        a0    = LEVELS'(lo_c - EW'(1));
        b0    = LEVELS'(hi_c - EW'(1));
    end

    always_comb
    begin
        p_cur        = side_reg ? pr_reg : pl_reg;
        c0_addr      = {p_cur[AW-2:0], 1'b0};
        c1_addr      = {p_cur[AW-2:0], 1'b1};
        lnode        = l_reg[AW-1:0];
        rnode        = AW'(r_reg - BW'(1));
        same_node    = (pl_reg == pr_reg);
        push_last    = (h_reg == HW'(1));
        push_done    = side_reg && push_last;
        rebuild_done = side_reg && (h_reg == HW'(LEVELS));
        span_h       = CW'(1) << h_reg;
        span_c       = CW'(1) << (h_reg - HW'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rfrc_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = rfrc_pkg::ST_IDLE;
                end
            end
            rfrc_pkg::ST_IDLE:
            begin
                if (start && !empty)
                begin
                    state_next = rfrc_pkg::ST_P_RD;
                end
            end
            rfrc_pkg::ST_P_RD:
            begin
                if (side_reg && same_node)
                begin
                    state_next = push_done ? rfrc_pkg::ST_A_STEP : rfrc_pkg::ST_P_RD;
                end
                else
                begin
                    state_next = rfrc_pkg::ST_P_CHK;
                end
            end
            rfrc_pkg::ST_P_CHK:
            begin
                if (rd_data_a[CW])
                begin
                    state_next = rfrc_pkg::ST_P_WL;
                end
                else
                begin
                    state_next = push_done ? rfrc_pkg::ST_A_STEP : rfrc_pkg::ST_P_RD;
                end
            end
            rfrc_pkg::ST_P_WL:
            begin
                state_next = rfrc_pkg::ST_P_WR;
            end
            rfrc_pkg::ST_P_WR:
            begin
                state_next = push_done ? rfrc_pkg::ST_A_STEP : rfrc_pkg::ST_P_RD;
            end
            rfrc_pkg::ST_A_STEP:
            begin
                if (l_reg < r_reg)
                begin
                    state_next = rfrc_pkg::ST_A_LEFT;
                end
                else if (func_reg == rfrc_pkg::FUNC_COUNT)
                begin
                    state_next = rfrc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rfrc_pkg::ST_B_RD;
                end
            end
            rfrc_pkg::ST_A_LEFT:
            begin
                state_next = rfrc_pkg::ST_A_RIGHT;
            end
            rfrc_pkg::ST_A_RIGHT:
            begin
                state_next = rfrc_pkg::ST_A_STEP;
            end
            rfrc_pkg::ST_B_RD:
            begin
                if (side_reg && same_node)
                begin
                    state_next = rebuild_done ? rfrc_pkg::ST_IDLE : rfrc_pkg::ST_B_RD;
                end
                else
                begin
                    state_next = rfrc_pkg::ST_B_SUM;
                end
            end
            rfrc_pkg::ST_B_SUM:
            begin
                state_next = rfrc_pkg::ST_B_WR;
            end
            rfrc_pkg::ST_B_WR:
            begin
                state_next = rebuild_done ? rfrc_pkg::ST_IDLE : rfrc_pkg::ST_B_RD;
            end
            default:
            begin
                state_next = rfrc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        mem_ctl    = '0;
        rd_addr_a  = p_cur;
        rd_addr_b  = p_cur;
        wr_addr    = p_cur;
        wr_data    = '0;
        alu_op     = rfrc_pkg::ALU_NONE;
        alu_span   = span_h;
        func_next  = func_reg;
        pl_next    = pl_reg;
        pr_next    = pr_reg;
        lpath_next = lpath_reg;
        rpath_next = rpath_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        h_next     = h_reg;
        side_next  = side_reg;
        lsel_next  = lsel_reg;
        rsel_next  = rsel_reg;
        acc_next   = acc_reg;
        size_next  = size_reg;
        sum_next   = sum_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        up_next    = up_reg;

        case (state_reg)
            rfrc_pkg::ST_CLEAR:
            begin
                mem_ctl.wr = 1'b1;
                wr_addr    = clr_reg;
                wr_data    = '0;
                clr_next   = clr_reg + AW'(1);
            end
            rfrc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    if (empty)
                    begin
                        if (func == rfrc_pkg::FUNC_COUNT)
                        begin
                            done_next = 1'b1;
                            up_next   = '0;
                        end
                    end
                    else
                    begin
                        h_next     = HW'(LEVELS);
                        side_next  = 1'b0;
                        pl_next    = AW'(1);
                        pr_next    = AW'(1);
                        lpath_next = a0;
                        rpath_next = b0;
                        l_next     = BW'(P2) + BW'(a0);
                        r_next     = BW'(P2) + BW'(b0) + BW'(1);
                        size_next  = CW'(hi_c - lo_c + EW'(1));
                        acc_next   = CW'(hi_c - lo_c + EW'(1));
                    end
                end
            end
            rfrc_pkg::ST_P_RD,
            rfrc_pkg::ST_P_CHK,
            rfrc_pkg::ST_P_WL,
            rfrc_pkg::ST_P_WR:
            begin
                alu_span = span_c;
                if (state_reg == rfrc_pkg::ST_P_RD && !(side_reg && same_node))
                begin
                    mem_ctl.rd = 1'b1;
                    rd_addr_a  = p_cur;
                end
                if (state_reg == rfrc_pkg::ST_P_CHK && rd_data_a[CW])
                begin
                    // clear the mark here and fetch both children
                    mem_ctl.wr = 1'b1;
                    wr_addr    = p_cur;
                    wr_data    = {1'b0, rd_data_a[CW-1:0]};
                    mem_ctl.rd = 1'b1;
                    rd_addr_a  = c0_addr;
                    rd_addr_b  = c1_addr;
                end
                if (state_reg == rfrc_pkg::ST_P_WL)
                begin
                    alu_op     = rfrc_pkg::ALU_FLIP_A;
                    mem_ctl.wr = 1'b1;
                    wr_addr    = c0_addr;
                    wr_data    = {~rd_data_a[CW], alu_res};
                end
                if (state_reg == rfrc_pkg::ST_P_WR)
                begin
                    alu_op     = rfrc_pkg::ALU_FLIP_B;
                    mem_ctl.wr = 1'b1;
                    wr_addr    = c1_addr;
                    wr_data    = {~rd_data_b[CW], alu_res};
                end
                if ((state_reg == rfrc_pkg::ST_P_RD && side_reg && same_node) ||
                    (state_reg == rfrc_pkg::ST_P_CHK && !rd_data_a[CW]) ||
                    (state_reg == rfrc_pkg::ST_P_WR))
                begin
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                    end
                    else
                    begin
                        // step both paths one level down
                        side_next  = 1'b0;
                        pl_next    = {pl_reg[AW-2:0], lpath_reg[LEVELS-1]};
                        pr_next    = {pr_reg[AW-2:0], rpath_reg[LEVELS-1]};
                        lpath_next = lpath_reg << 1;
                        rpath_next = rpath_reg << 1;
                        h_next     = push_last ? '0 : h_reg - HW'(1);
                    end
                end
            end
            rfrc_pkg::ST_A_STEP:
            begin
                if (l_reg < r_reg)
                begin
                    mem_ctl.rd = 1'b1;
                    rd_addr_a  = lnode;
                    rd_addr_b  = rnode;
                    lsel_next  = l_reg[0];
                    rsel_next  = r_reg[0];
                end
                else if (func_reg == rfrc_pkg::FUNC_COUNT)
                begin
                    done_next = 1'b1;
                    up_next   = OUT_W'(acc_reg);
                end
                else
                begin
                    h_next    = HW'(1);
                    side_next = 1'b0;
                    pl_next   = pl_reg >> 1;
                    pr_next   = pr_reg >> 1;
                end
            end
            rfrc_pkg::ST_A_LEFT:
            begin
                if (lsel_reg)
                begin
                    if (func_reg == rfrc_pkg::FUNC_COUNT)
                    begin
                        alu_op   = rfrc_pkg::ALU_TAKE_A;
                        acc_next = alu_res;
                    end
                    else
                    begin
                        alu_op     = rfrc_pkg::ALU_FLIP_A;
                        mem_ctl.wr = 1'b1;
                        wr_addr    = lnode;
                        wr_data    = {~rd_data_a[CW], alu_res};
                    end
                end
            end
            rfrc_pkg::ST_A_RIGHT:
            begin
                if (rsel_reg)
                begin
                    if (func_reg == rfrc_pkg::FUNC_COUNT)
                    begin
                        alu_op   = rfrc_pkg::ALU_TAKE_B;
                        acc_next = alu_res;
                    end
                    else
                    begin
                        alu_op     = rfrc_pkg::ALU_FLIP_B;
                        mem_ctl.wr = 1'b1;
                        wr_addr    = rnode;
                        wr_data    = {~rd_data_b[CW], alu_res};
                    end
                end
                l_next = (l_reg + BW'(lsel_reg)) >> 1;
                r_next = (r_reg - BW'(rsel_reg)) >> 1;
                h_next = h_reg + HW'(1);
            end
            rfrc_pkg::ST_B_RD:
            begin
                if (side_reg && same_node)
                begin
                    side_next = 1'b0;
                    if (!rebuild_done)
                    begin
                        h_next  = h_reg + HW'(1);
                        pl_next = pl_reg >> 1;
                        pr_next = pr_reg >> 1;
                    end
                end
                else
                begin
                    mem_ctl.rd = 1'b1;
                    rd_addr_a  = c0_addr;
                    rd_addr_b  = c1_addr;
                end
            end
            rfrc_pkg::ST_B_SUM:
            begin
                alu_op     = rfrc_pkg::ALU_SUM;
                sum_next   = alu_res;
                mem_ctl.rd = 1'b1;
                rd_addr_a  = p_cur;
                rd_addr_b  = p_cur;
            end
            rfrc_pkg::ST_B_WR:
            begin
                alu_op     = rfrc_pkg::ALU_FIX;
                mem_ctl.wr = 1'b1;
                wr_addr    = p_cur;
                wr_data    = {rd_data_a[CW], alu_res};
                if (!side_reg)
                begin
                    side_next = 1'b1;
                end
                else
                begin
                    side_next = 1'b0;
                    if (!rebuild_done)
                    begin
                        h_next  = h_reg + HW'(1);
                        pl_next = pl_reg >> 1;
                        pr_next = pr_reg >> 1;
                    end
                end
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfrc_pkg::ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        pl_reg    <= pl_next;
        pr_reg    <= pr_next;
        lpath_reg <= lpath_next;
        rpath_reg <= rpath_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        h_reg     <= h_next;
        side_reg  <= side_next;
        lsel_reg  <= lsel_next;
        rsel_reg  <= rsel_next;
        acc_reg   <= acc_next;
        size_reg  <= size_next;
        sum_reg   <= sum_next;
        up_reg    <= up_next;
    end

    assign busy     = (state_reg != rfrc_pkg::ST_IDLE);
    assign done     = done_reg;
    assign up_count = up_reg;

    `RFRC_CHECK(a_done_not_busy, clk, rst_n, done, !busy, "result word while busy")
    `RFRC_CHECK(a_clear_quiet, clk, rst_n, state_reg == rfrc_pkg::ST_CLEAR, !done, "result word during clear")
    `RFRC_CHECK(a_count_no_write, clk, rst_n, (state_reg == rfrc_pkg::ST_A_LEFT || state_reg == rfrc_pkg::ST_A_RIGHT) && func_reg == rfrc_pkg::FUNC_COUNT, !mem_ctl.wr, "count wrote node memory")
    `RFRC_CHECK(a_acc_bound, clk, rst_n, state_reg == rfrc_pkg::ST_A_STEP && func_reg == rfrc_pkg::FUNC_COUNT, acc_reg <= size_reg, "count exceeds range size")
    `RFRC_CHECK_NEXT(a_start_walk, clk, rst_n, start && !busy && !empty, busy, "walk did not start")

endmodule

`default_nettype wire

// ===== hdl/rfrc_node_mem.sv =====
`default_nettype none

module rfrc_node_mem #(
    parameter int AW = 11,
    parameter int DW = 12
) (
    input  wire logic              clk,
    input  wire rfrc_pkg::mem_ctl_t ctl,
    input  wire logic [AW-1:0]     rd_addr_a,
    input  wire logic [AW-1:0]     rd_addr_b,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DW-1:0]     wr_data,
    output logic      [DW-1:0]     rd_data_a,
    output logic      [DW-1:0]     rd_data_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (ctl.rd)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== hdl/rfrc_node_alu.sv =====
`default_nettype none

module rfrc_node_alu #(
    parameter int CW = 11
) (
    input  wire rfrc_pkg::alu_op_t op,
    input  wire logic          mark,
    input  wire logic [CW-1:0] span,
    input  wire logic [CW-1:0] acc,
    input  wire logic [CW-1:0] sum,
    input  wire logic [CW-1:0] cnt_a,
    input  wire logic [CW-1:0] cnt_b,
    output logic      [CW-1:0] res
);

    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          sub;

    always_comb
    begin
        x   = '0;
        y   = '0;
        sub = 1'b0;
        case (op)
            rfrc_pkg::ALU_FLIP_A:
            begin
                x   = span;
                y   = cnt_a;
                sub = 1'b1;
            end
            rfrc_pkg::ALU_FLIP_B:
            begin
                x   = span;
                y   = cnt_b;
                sub = 1'b1;
            end
            rfrc_pkg::ALU_SUM:
            begin
                x = cnt_a;
                y = cnt_b;
            end
            rfrc_pkg::ALU_FIX:
            begin
                // a marked node holds the complement of its children's sum
                x   = mark ? span : sum;
                y   = mark ? sum : '0;
                sub = 1'b1;
            end
            rfrc_pkg::ALU_TAKE_A:
            begin
                x   = acc;
                y   = cnt_a;
                sub = 1'b1;
            end
            rfrc_pkg::ALU_TAKE_B:
            begin
                x   = acc;
                y   = cnt_b;
                sub = 1'b1;
            end
            default:
            begin
                x   = '0;
                y   = '0;
                sub = 1'b0;
            end
        endcase
        res = sub ? (x - y) : (x + y);
    end

endmodule

`default_nettype wire

// ===== sim/tb_range_flip_range_count.sv =====
`default_nettype none

module tb_range_flip_range_count;

    localparam int POSITIONS = 1024;
    localparam int NODES = 2 * POSITIONS - 1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_WORDS = 1300;
    localparam int QUIET_TAIL = 120;

    typedef struct {
        logic                           func;
        logic [rfrc_pkg::RANGE_W-1:0]   lo;
        logic [rfrc_pkg::RANGE_W-1:0]   hi;
    } word_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         func = rfrc_pkg::FUNC_FLIP;
    logic [rfrc_pkg::RANGE_W-1:0] range_low = '0;
    logic [rfrc_pkg::RANGE_W-1:0] range_high = '0;
    logic                         done;
    logic [rfrc_pkg::COUNT_W-1:0] up_count;

    range_flip_range_count #(
        .POSITIONS (POSITIONS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .range_low  (range_low),
        .range_high (range_high),
        .done       (done),
        .up_count   (up_count)
    );

    // shadow segment tree: face-up count and pending flip per node
    logic [rfrc_pkg::COUNT_W-1:0] seg_up [NODES];
    logic                         seg_flip [NODES];

    word_t                        pending_words [$];
    logic [rfrc_pkg::COUNT_W-1:0] expected_counts [$];
    int                           mismatches = 0;
    int                           cycles = 0;
    int                           gap_left = 0;
    logic [rfrc_pkg::COUNT_W-1:0] want;

    function automatic void seg_build(int v, int lo, int hi);
        int mid;
        seg_up[v] = rfrc_pkg::COUNT_W'(hi - lo + 1);
        seg_flip[v] = 1'b0;
        if (lo < hi) begin
            mid = (lo + hi) / 2;
            seg_build(v + 1, lo, mid);
            seg_build(v + 2 * (mid - lo + 1), mid + 1, hi);
        end
    endfunction

    function automatic void seg_toggle(int v, int lo, int hi);
        seg_up[v] = rfrc_pkg::COUNT_W'(hi - lo + 1) - seg_up[v];
        seg_flip[v] = ~seg_flip[v];
    endfunction

    function automatic void seg_push(int v, int lo, int mid, int hi);
        if (seg_flip[v]) begin
            seg_toggle(v + 1, lo, mid);
            seg_toggle(v + 2 * (mid - lo + 1), mid + 1, hi);
            seg_flip[v] = 1'b0;
        end
    endfunction

    function automatic void seg_flip_range(int v, int lo, int hi, int a, int b);
        int mid;
        int rc;
        if (b < lo || a > hi)
            return;
        if (a <= lo && hi <= b) begin
            seg_toggle(v, lo, hi);
            return;
        end
        mid = (lo + hi) / 2;
        rc = v + 2 * (mid - lo + 1);
        seg_push(v, lo, mid, hi);
        seg_flip_range(v + 1, lo, mid, a, b);
        seg_flip_range(rc, mid + 1, hi, a, b);
        seg_up[v] = seg_up[v + 1] + seg_up[rc];
    endfunction

    function automatic int seg_count(int v, int lo, int hi, int a, int b);
        int mid;
        int rc;
        if (b < lo || a > hi)
            return 0;
        if (a <= lo && hi <= b)
            return int'(seg_up[v]);
        mid = (lo + hi) / 2;
        rc = v + 2 * (mid - lo + 1);
        seg_push(v, lo, mid, hi);
        return seg_count(v + 1, lo, mid, a, b) + seg_count(rc, mid + 1, hi, a, b);
    endfunction

    // applies one word to the shadow tree; pushes the expected count for a count word
    function automatic void predict_word(logic f, logic [rfrc_pkg::RANGE_W-1:0] lo_in,
                                         logic [rfrc_pkg::RANGE_W-1:0] hi_in);
        int a;
        int b;
        a = (lo_in < 1) ? 1 : int'(lo_in);
        b = (hi_in > POSITIONS) ? POSITIONS : int'(hi_in);
        if (f == rfrc_pkg::FUNC_FLIP) begin
            if (a <= b)
                seg_flip_range(0, 1, POSITIONS, a, b);
        end else if (a > b) begin
            expected_counts.push_back('0);
        end else begin
            expected_counts.push_back(rfrc_pkg::COUNT_W'(seg_count(0, 1, POSITIONS, a, b)));
        end
    endfunction

    task automatic add_word(logic f, int lo, int hi);
        word_t w;
        w.func = f;
        w.lo = rfrc_pkg::RANGE_W'(lo);
        w.hi = rfrc_pkg::RANGE_W'(hi);
        pending_words.push_back(w);
    endtask

    task automatic drive_next();
        word_t w;
        if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            start <= 1'b1;
            func <= w.func;
            range_low <= w.lo;
            range_high <= w.hi;
        end else begin
            start <= 1'b0;
        end
    endtask

    task automatic report(string what, int exp_val, int act_val);
        if (mismatches < 10)
            $display("%s: expected %0d, got %0d", what, exp_val, act_val);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // driver: a word goes in when start is high and busy is low
    always @(posedge clk)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            predict_word(func, range_low, range_high);
            if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 1) == 1) begin
                start <= 1'b0;
                gap_left <= $urandom_range(1, 3);
            end else begin
                drive_next();
            end
        end else if (!start) begin
            // idle cycles only count once the block is free
            if (gap_left != 0) begin
                if (!busy)
                    gap_left <= gap_left - 1;
            end else begin
                drive_next();
            end
        end
    end

    // monitor: every done strobe carries one count word
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_counts.size() == 0) begin
                report("unexpected count word", -1, int'(up_count));
            end else begin
                want = expected_counts.pop_front();
                if (up_count !== want)
                    report("up_count mismatch", int'(want), int'(up_count));
            end
        end
    end

    initial
    begin
        int sel;
        int a;
        int b;
        int t;

        seg_build(0, 1, POSITIONS);

        add_word(rfrc_pkg::FUNC_COUNT, 1, 1024);
        add_word(rfrc_pkg::FUNC_COUNT, 0, 2047);
        add_word(rfrc_pkg::FUNC_FLIP, 1, 1);
        add_word(rfrc_pkg::FUNC_FLIP, 1024, 1024);
        add_word(rfrc_pkg::FUNC_COUNT, 1, 1024);
        add_word(rfrc_pkg::FUNC_COUNT, 1, 1);
        add_word(rfrc_pkg::FUNC_COUNT, 1024, 2047);
        add_word(rfrc_pkg::FUNC_FLIP, 512, 513);
        add_word(rfrc_pkg::FUNC_COUNT, 513, 513);
        add_word(rfrc_pkg::FUNC_COUNT, 500, 600);
        add_word(rfrc_pkg::FUNC_FLIP, 0, 2047);
        add_word(rfrc_pkg::FUNC_COUNT, 0, 1024);
        add_word(rfrc_pkg::FUNC_COUNT, 2, 1023);
        // empty after clipping: count gives zero, flip is a no-op
        add_word(rfrc_pkg::FUNC_COUNT, 5, 4);
        add_word(rfrc_pkg::FUNC_FLIP, 700, 3);
        add_word(rfrc_pkg::FUNC_COUNT, 2047, 0);
        add_word(rfrc_pkg::FUNC_COUNT, 1025, 2047);
        add_word(rfrc_pkg::FUNC_COUNT, 0, 0);
        add_word(rfrc_pkg::FUNC_FLIP, 1025, 1100);
        add_word(rfrc_pkg::FUNC_FLIP, 0, 0);
        add_word(rfrc_pkg::FUNC_COUNT, 1, 1024);
        add_word(rfrc_pkg::FUNC_FLIP, 2, 1023);
        add_word(rfrc_pkg::FUNC_COUNT, 1, 1024);
        add_word(rfrc_pkg::FUNC_COUNT, 1023, 1024);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // raw field values, often out of the row or reversed
                a = $urandom_range(0, 2047);
                b = $urandom_range(0, 2047);
            end else if (sel <= 3) begin
                a = $urandom_range(1, 1024);
                b = a + $urandom_range(0, 7);
                if (b > 1024)
                    b = 1024;
            end else begin
                a = $urandom_range(1, 1024);
                b = $urandom_range(1, 1024);
                if (a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            add_word($urandom_range(0, 1) == 1 ? rfrc_pkg::FUNC_COUNT : rfrc_pkg::FUNC_FLIP,
                     a, b);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/rfrc_pkg.sv
hdl/rfrc_node_mem.sv
hdl/rfrc_node_alu.sv
hdl/range_flip_range_count.sv
sim/tb_range_flip_range_count.sv
